// ===== hdl/fmvn_pkg.sv =====
package fmvn_pkg;

    localparam int MaxFeatures    = 64;
    localparam int FeatIdxBits    = 6;
    localparam int FrameCountBits = 20;
    localparam int SumBits        = 36;
    localparam int SqBits         = 52;
    localparam int QueueDepth     = 4;
    localparam int QueuePtrBits   = 2;

    typedef enum logic [1:0] {
        MODE_ACCUM     = 2'd0,
        MODE_FINISH    = 2'd1,
        MODE_NORMALIZE = 2'd2,
        MODE_NONE      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFRAMES = 3'd1,
        ST_VARFLOOR = 3'd2,
        ST_SINGLE   = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    localparam logic [1:0] CFG_FEATURE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_TARGET_MEAN    = 2'd1;
    localparam logic [1:0] CFG_TARGET_STD     = 2'd2;
    localparam logic [1:0] CFG_VARIANCE_FLOOR = 2'd3;

    // one classified item passed from front to back
    typedef struct packed {
        mode_t              mode;
        logic [5:0]         idx;
        logic signed [15:0] x;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic empty;
        logic full;
    } q_ctl_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_ACC_RD,
        B_ACC_WR,
        B_FIN_RD,
        B_FIN_MUL,
        B_FIN_SUB,
        B_FIN_VDIV,
        B_FIN_MDIV,
        B_FIN_RDIV,
        B_FIN_SQRT,
        B_FIN_WR,
        B_NRM_RD,
        B_NRM_M1,
        B_NRM_M2,
        B_NRM_M3,
        B_NRM_OUT,
        B_DONE
    } bstate_t;

endpackage

// ===== hdl/fmvn_front.sv =====
module fmvn_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [5:0]           feature_index,
    input  logic signed [15:0]   sample_value,
    input  logic                 pop,
    output fmvn_pkg::cmd_t       head,
    output logic                 head_valid
);
    fmvn_pkg::cmd_t mem [fmvn_pkg::QueueDepth];
    logic [fmvn_pkg::QueuePtrBits-1:0] wr_reg, rd_reg;
    logic [fmvn_pkg::QueuePtrBits:0]   cnt_reg;
    fmvn_pkg::q_ctl_t ctl;
    fmvn_pkg::cmd_t   in_cmd;

    always_comb
    begin
        in_cmd.mode = fmvn_pkg::mode_t'(mode);
        in_cmd.idx  = feature_index;
        in_cmd.x    = sample_value;
        ctl.empty = (cnt_reg == '0);
        ctl.full  = (cnt_reg == (fmvn_pkg::QueuePtrBits+1)'(fmvn_pkg::QueueDepth));
        // mode three never enters the queue
        ctl.push  = start && !ctl.full && (in_cmd.mode != fmvn_pkg::MODE_NONE);
        ctl.pop   = pop && !ctl.empty;
    end

    assign busy       = ctl.full;
    assign head       = mem[rd_reg];
    assign head_valid = !ctl.empty;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (ctl.push) wr_reg <= wr_reg + 1'b1;
            if (ctl.pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (fmvn_pkg::QueuePtrBits+1)'(ctl.push)
                               - (fmvn_pkg::QueuePtrBits+1)'(ctl.pop);
        end
    end
endmodule

// ===== hdl/fmvn_back.sv =====
module fmvn_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fmvn_pkg::cmd_t       head,
    input  logic                 head_valid,
    output logic                 pop,
    input  logic [6:0]           fcount,
    input  logic signed [15:0]   tmean,
    input  logic [15:0]          tstd,
    input  logic [31:0]          vfloor,
    output logic                 done,
    output logic signed [15:0]   normalized_value,
    output logic [2:0]           status,
    output logic                 is_statistics_result
);
    fmvn_pkg::bstate_t st_reg, st_next;

    logic [fmvn_pkg::SumBits-1:0] sum_mem [fmvn_pkg::MaxFeatures];
    logic [fmvn_pkg::SqBits-1:0]  sq_mem  [fmvn_pkg::MaxFeatures];
    logic [15:0]                  mean_mem [fmvn_pkg::MaxFeatures];
    logic [31:0]                  inv_mem  [fmvn_pkg::MaxFeatures];
    logic [fmvn_pkg::MaxFeatures-1:0] sval_reg;  // sums valid, else read zero

    fmvn_pkg::cmd_t cmd_reg;
    logic [fmvn_pkg::SumBits-1:0] s_rd_reg;
    logic [fmvn_pkg::SqBits-1:0]  q_rd_reg;
    logic [15:0] m_rd_reg;
    logic [31:0] i_rd_reg;
    logic [fmvn_pkg::FrameCountBits-1:0] frames_reg;
    logic [6:0] fi_reg;
    logic anyfail_reg;
    logic [2:0] stat_fin_reg;
    logic [fmvn_pkg::FrameCountBits-1:0] nsave_reg;

    // finish datapath
    logic [35:0]  mag_reg;
    logic         neg_reg;
    logic [127:0] num_reg;     // dividend / partial products
    logic [127:0] prod_reg;
    logic [63:0]  den_reg;
    logic [64:0]  rem_reg;
    logic [63:0]  quo_reg;
    logic         big_reg;
    logic [6:0]   cyc_reg;
    logic [31:0]  var_reg;
    logic [15:0]  mean_reg;
    logic [63:0]  sx_reg;      // sqrt operand
    logic [63:0]  sres_reg;
    logic [63:0]  sbit_reg;
    logic [1:0]   mstep_reg;

    // normalize datapath
    logic [16:0]  dmag_reg;
    logic         dneg_reg;
    logic [48:0]  p1_reg;
    logic [64:0]  p2_reg;
    logic signed [17:0] v_reg;

    logic [6:0] fc_eff;
    assign fc_eff = (fcount > 7'(fmvn_pkg::MaxFeatures)) ? 7'(fmvn_pkg::MaxFeatures) : fcount;

    logic [5:0] fidx;
    assign fidx = fi_reg[5:0];

    // the walk reads the next feature while its index is being latched
    logic [5:0] rd_addr;
    assign rd_addr = (st_reg == fmvn_pkg::B_FIN_RD) ? fidx : cmd_reg.idx;

    // restoring divider step
    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [6:0]  bitpos;
    always_comb
    begin
        rem_sh = {rem_reg[63:0], num_reg[127]};
        rem_ge = rem_reg[63] || (rem_sh >= {1'b0, den_reg});
        bitpos = 7'd127 - cyc_reg;
    end

    logic [63:0] sq_try;
    assign sq_try = sres_reg + sbit_reg;

    always_comb
    begin
        st_next = st_reg;
        pop = 1'b0;
        unique case (st_reg)
            fmvn_pkg::B_IDLE:
                if (head_valid)
                begin
                    pop = 1'b1;
                    unique case (head.mode)
                        fmvn_pkg::MODE_ACCUM:     st_next = fmvn_pkg::B_ACC_RD;
                        fmvn_pkg::MODE_FINISH:    st_next = fmvn_pkg::B_FIN_RD;
                        fmvn_pkg::MODE_NORMALIZE: st_next = fmvn_pkg::B_NRM_RD;
                        default:                  st_next = fmvn_pkg::B_IDLE;
                    endcase
                end
            fmvn_pkg::B_ACC_RD:  st_next = fmvn_pkg::B_ACC_WR;
            fmvn_pkg::B_ACC_WR:  st_next = fmvn_pkg::B_IDLE;
            fmvn_pkg::B_FIN_RD:
                if (fi_reg >= fc_eff)            st_next = fmvn_pkg::B_DONE;
                else if (frames_reg == '0)       st_next = fmvn_pkg::B_FIN_WR;
                else                             st_next = fmvn_pkg::B_FIN_MUL;
            fmvn_pkg::B_FIN_MUL:
                if (mstep_reg == 2'd2)           st_next = fmvn_pkg::B_FIN_SUB;
            fmvn_pkg::B_FIN_SUB:  st_next = fmvn_pkg::B_FIN_VDIV;
            fmvn_pkg::B_FIN_VDIV:
                if (cyc_reg == 7'd127)           st_next = fmvn_pkg::B_FIN_MDIV;
            fmvn_pkg::B_FIN_MDIV:
                if (cyc_reg == 7'd127)           st_next = fmvn_pkg::B_FIN_RDIV;
            fmvn_pkg::B_FIN_RDIV:
                if (cyc_reg == 7'd127)           st_next = fmvn_pkg::B_FIN_SQRT;
            fmvn_pkg::B_FIN_SQRT:
                if (sbit_reg == '0)              st_next = fmvn_pkg::B_FIN_WR;
            fmvn_pkg::B_FIN_WR:  st_next = fmvn_pkg::B_FIN_RD;
            fmvn_pkg::B_NRM_RD:  st_next = fmvn_pkg::B_NRM_M1;
            fmvn_pkg::B_NRM_M1:  st_next = fmvn_pkg::B_NRM_M2;
            fmvn_pkg::B_NRM_M2:  st_next = fmvn_pkg::B_NRM_M3;
            fmvn_pkg::B_NRM_M3:  st_next = fmvn_pkg::B_NRM_OUT;
            fmvn_pkg::B_NRM_OUT: st_next = fmvn_pkg::B_IDLE;
            fmvn_pkg::B_DONE:    st_next = fmvn_pkg::B_IDLE;
            default:             st_next = fmvn_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= fmvn_pkg::B_IDLE;
            sval_reg   <= '0;
            frames_reg <= '0;
            done       <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            done   <= (st_reg == fmvn_pkg::B_NRM_OUT) || (st_reg == fmvn_pkg::B_DONE);
            if (st_reg == fmvn_pkg::B_ACC_WR && {1'b0, cmd_reg.idx} < fc_eff)
            begin
                sval_reg[cmd_reg.idx] <= 1'b1;
                if (cmd_reg.idx == '0 && frames_reg != '1)
                    frames_reg <= frames_reg + 1'b1;
            end
            if (st_reg == fmvn_pkg::B_FIN_WR)
                sval_reg[fidx] <= 1'b0;
            if (st_reg == fmvn_pkg::B_DONE)
                frames_reg <= '0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        s_rd_reg <= sum_mem[rd_addr];
        q_rd_reg <= sq_mem[rd_addr];
        m_rd_reg <= mean_mem[rd_addr];
        i_rd_reg <= inv_mem[rd_addr];
        if (st_reg == fmvn_pkg::B_ACC_WR && {1'b0, cmd_reg.idx} < fc_eff)
        begin
            sum_mem[cmd_reg.idx] <= (sval_reg[cmd_reg.idx] ? s_rd_reg : '0)
                + {{(fmvn_pkg::SumBits-16){cmd_reg.x[15]}}, cmd_reg.x};
            sq_mem[cmd_reg.idx]  <= (sval_reg[cmd_reg.idx] ? q_rd_reg : '0)
                + fmvn_pkg::SqBits'(unsigned'(32'(cmd_reg.x * cmd_reg.x)));
        end
        if (st_reg == fmvn_pkg::B_FIN_WR)
        begin
            mean_mem[fidx] <= (frames_reg == '0) ? 16'd0 : mean_reg;
            inv_mem[fidx]  <= (frames_reg == '0 || var_reg == '0 || var_reg < vfloor)
                              ? 32'd0 : sres_reg[31:0];
        end
    end

    logic [35:0] s_eff;
    logic [51:0] q_eff;
    assign s_eff = sval_reg[fidx] ? s_rd_reg : '0;
    assign q_eff = sval_reg[fidx] ? q_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (st_reg == fmvn_pkg::B_IDLE && head_valid)
        begin
            cmd_reg     <= head;
            fi_reg      <= '0;
            anyfail_reg <= 1'b0;
        end
        unique case (st_reg)
            fmvn_pkg::B_FIN_RD:
            begin
                cmd_reg.idx <= fidx;
                mstep_reg   <= '0;
            end
            fmvn_pkg::B_FIN_MUL:
            begin
                mstep_reg <= mstep_reg + 1'b1;
                unique case (mstep_reg)
                    2'd0:
                    begin
                        neg_reg  <= s_eff[35];
                        mag_reg  <= s_eff[35] ? (~s_eff + 1'b1) : s_eff;
                        num_reg  <= 128'(q_eff[31:0] * 52'(frames_reg));
                    end
                    2'd1:
                    begin
                        num_reg  <= num_reg + ((128'(q_eff[51:32]) * 128'(frames_reg)) << 32);
                        prod_reg <= 128'(mag_reg[17:0] * mag_reg);
                    end
                    default:
                    begin
                        prod_reg <= prod_reg + ((128'(mag_reg[35:18]) * 128'(mag_reg)) << 18);
                        den_reg  <= 64'(frames_reg) * 64'(frames_reg);
                    end
                endcase
            end
            fmvn_pkg::B_FIN_SUB:
            begin
                num_reg <= (num_reg >= prod_reg) ? num_reg - prod_reg : '0;
                rem_reg <= '0;
                quo_reg <= '0;
                big_reg <= 1'b0;
                cyc_reg <= '0;
            end
            fmvn_pkg::B_FIN_VDIV, fmvn_pkg::B_FIN_MDIV, fmvn_pkg::B_FIN_RDIV:
            begin
                num_reg <= {num_reg[126:0], 1'b0};
                rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                if (rem_ge)
                begin
                    if (bitpos >= 7'd32 && st_reg == fmvn_pkg::B_FIN_VDIV) big_reg <= 1'b1;
                    else quo_reg[bitpos[5:0]] <= 1'b1;
                end
                cyc_reg <= cyc_reg + 1'b1;
                if (cyc_reg == 7'd127)
                begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    big_reg <= 1'b0;
                    unique case (st_reg)
                        fmvn_pkg::B_FIN_VDIV:
                        begin
                            // last step lands on bit 0
                            var_reg <= big_reg ? 32'hFFFF_FFFF
                                               : (quo_reg[31:0] | 32'(rem_ge));
                            // mean: (mag + n/2) / n
                            num_reg <= 128'(mag_reg) + 128'(frames_reg >> 1);
                            den_reg <= 64'(frames_reg);
                        end
                        fmvn_pkg::B_FIN_MDIV:
                        begin
                            logic [63:0] mm;
                            mm = quo_reg | (64'(rem_ge) << bitpos[5:0]);
                            if (mm > 64'd32768) mm = 64'd32768;
                            if (neg_reg) mean_reg <= 16'(-mm);
                            else mean_reg <= (mm > 64'd32767) ? 16'h7FFF : mm[15:0];
                            num_reg <= 128'(64'h4000_0000_0000_0000);
                            den_reg <= (var_reg == '0) ? 64'd1 : 64'(var_reg);
                        end
                        default:
                        begin
                            sx_reg   <= quo_reg | (64'(rem_ge) << bitpos[5:0]);
                            sres_reg <= '0;
                            sbit_reg <= 64'h4000_0000_0000_0000;
                        end
                    endcase
                end
            end
            fmvn_pkg::B_FIN_SQRT:
            begin
                // root is final once the bit runs out
                if (sbit_reg != '0)
                begin
                    if (sbit_reg > sx_reg && sres_reg == '0)
                        sbit_reg <= sbit_reg >> 2;
                    else
                    begin
                        if (sx_reg >= sq_try)
                        begin
                            sx_reg   <= sx_reg - sq_try;
                            sres_reg <= (sres_reg >> 1) + sbit_reg;
                        end
                        else sres_reg <= sres_reg >> 1;
                        sbit_reg <= sbit_reg >> 2;
                    end
                end
            end
            fmvn_pkg::B_FIN_WR:
            begin
                fi_reg <= fi_reg + 1'b1;
                if (frames_reg != '0 && (var_reg == '0 || var_reg < vfloor))
                    anyfail_reg <= 1'b1;
                if (frames_reg == '0) sres_reg <= '0;
            end
            fmvn_pkg::B_NRM_M1:
            begin
                logic signed [16:0] d;
                d = 17'(cmd_reg.x) - 17'(signed'(m_rd_reg));
                dneg_reg <= d[16];
                dmag_reg <= d[16] ? 17'(-d) : d;
            end
            fmvn_pkg::B_NRM_M2: p1_reg <= 49'(dmag_reg) * 49'(i_rd_reg);
            fmvn_pkg::B_NRM_M3: p2_reg <= 65'(p1_reg) * 65'(tstd);
            fmvn_pkg::B_NRM_OUT:
            begin
                logic [33:0] r;
                r = 34'((p2_reg + 65'(64'h4000_0000)) >> 31);
                v_reg <= 18'(dneg_reg ? -$signed({1'b0, r}) : $signed({1'b0, r}))
                         + 18'(tmean);
                // past 16 bits the sum saturates whatever the offset
                if (r > 34'hFFFF) v_reg <= dneg_reg ? -18'sd65536 : 18'sd65535;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        normalized_value     = '0;
        status               = fmvn_pkg::ST_OK;
        is_statistics_result = 1'b0;
        if (cmd_reg.mode == fmvn_pkg::MODE_FINISH)
        begin
            is_statistics_result = 1'b1;
            status = stat_fin_reg;
        end
        else
        begin
            if (v_reg > 18'sd32767)
            begin
                normalized_value = 16'sh7FFF;
                status = fmvn_pkg::ST_SAT;
            end
            else if (v_reg < -18'sd32768)
            begin
                normalized_value = -16'sd32768;
                status = fmvn_pkg::ST_SAT;
            end
            else normalized_value = v_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == fmvn_pkg::B_IDLE) nsave_reg <= frames_reg;
        if (st_reg == fmvn_pkg::B_DONE)
            stat_fin_reg <= (nsave_reg == '0) ? fmvn_pkg::ST_NOFRAMES
                          : (nsave_reg == 1)  ? fmvn_pkg::ST_SINGLE
                          : anyfail_reg       ? fmvn_pkg::ST_VARFLOOR
                          :                     fmvn_pkg::ST_OK;
    end
endmodule

// ===== hdl/feature_mean_variance_normalizer.sv =====
// Channel   | Ports                                          | Handshake
// input     | mode, feature_index, sample_value              | start && !busy
// result    | normalized_value, status, is_statistics_result | done (one cycle)
// config    | cfg_we, cfg_index, cfg_data                    | cfg_we
// A front queue of four entries takes items while the back unit works.
// Accumulate is a read-modify-write of the sum memories.
// Normalize uses two registered multiplies; finish runs, per feature, three
// 128-step dividers and a square root, and skips them with no frames.
// Reset clears control state; sums read zero through per-entry valid bits.
// The receiver cannot stall; busy rises only when the queue is full.
module feature_mean_variance_normalizer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [5:0]          feature_index,
    input  logic signed [15:0]  sample_value,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                done,
    output logic signed [15:0]  normalized_value,
    output logic [2:0]          status,
    output logic                is_statistics_result
);
    logic [6:0]         fcount_reg;
    logic signed [15:0] tmean_reg;
    logic [15:0]        tstd_reg;
    logic [31:0]        vfloor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcount_reg <= 7'd64;
            tmean_reg  <= '0;
            tstd_reg   <= 16'd4096;
            vfloor_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fmvn_pkg::CFG_FEATURE_COUNT:  fcount_reg <= cfg_data[6:0];
                fmvn_pkg::CFG_TARGET_MEAN:    tmean_reg  <= cfg_data[15:0];
                fmvn_pkg::CFG_TARGET_STD:     tstd_reg   <= cfg_data[15:0];
                default:                      vfloor_reg <= cfg_data;
            endcase
        end
    end

    fmvn_pkg::cmd_t head;
    logic head_valid, pop;

    fmvn_front u_front (
        .clk, .rst_n, .start, .busy, .mode, .feature_index, .sample_value,
        .pop, .head, .head_valid
    );

    fmvn_back u_back (
        .clk, .rst_n, .head, .head_valid, .pop,
        .fcount(fcount_reg), .tmean(tmean_reg), .tstd(tstd_reg), .vfloor(vfloor_reg),
        .done, .normalized_value, .status, .is_statistics_result
    );
endmodule

// ===== hdl/fmvn_checker.sv =====
module fmvn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        done,
    input logic [2:0]  status,
    input logic        is_statistics_result,
    input logic signed [15:0] normalized_value
);
    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_statistics_result |-> normalized_value == '0)
        else $error("finish result with nonzero value");
    a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && is_statistics_result |-> status != fmvn_pkg::ST_SAT)
        else $error("finish result reports saturation");
    a_nrm_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_statistics_result |->
            (status == fmvn_pkg::ST_OK || status == fmvn_pkg::ST_SAT))
        else $error("bad normalize status");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_statistics_result |=> !done)
        else $error("normalize results back to back");
endmodule

bind feature_mean_variance_normalizer fmvn_checker u_chk (
    .clk, .rst_n, .done, .status, .is_statistics_result,
    .normalized_value
);
